>>> rtl/u8cw_pkg.sv
// shared types, constants and range limits for the utf-8 cell width decoder
`default_nettype none

package u8cw_pkg;

    // running width accumulator size
    localparam int TOTAL_WIDTH_BITS = 16;

    // field widths fixed by the item formats
    localparam int BYTE_BITS    = 8;
    localparam int WIDTH_BITS   = 4;
    localparam int COUNT_BITS   = 3;
    localparam int CP_BITS      = 21;
    localparam int TOTAL_BITS   = 16;
    localparam int REM_BITS     = 2;

    // configuration reset
    localparam logic [WIDTH_BITS-1:0] TAB_WIDTH_RESET = 4'd4;

    // one-byte codes
    localparam logic [BYTE_BITS-1:0] TAB_BYTE      = 8'h09;
    localparam logic [BYTE_BITS-1:0] CTRL_LIMIT    = 8'h20;
    localparam logic [BYTE_BITS-1:0] CONT_MASK     = 8'h3F;
    localparam logic [BYTE_BITS-1:0] LEAD2_MASK    = 8'h1F;
    localparam logic [BYTE_BITS-1:0] LEAD3_MASK    = 8'h0F;
    localparam logic [BYTE_BITS-1:0] LEAD4_MASK    = 8'h07;

    // sequence lengths
    localparam logic [COUNT_BITS-1:0] LEN_1 = 3'd1;
    localparam logic [COUNT_BITS-1:0] LEN_2 = 3'd2;
    localparam logic [COUNT_BITS-1:0] LEN_3 = 3'd3;
    localparam logic [COUNT_BITS-1:0] LEN_4 = 3'd4;

    // cell widths
    localparam logic [WIDTH_BITS-1:0] W_ZERO   = 4'd0;
    localparam logic [WIDTH_BITS-1:0] W_NARROW = 4'd1;
    localparam logic [WIDTH_BITS-1:0] W_WIDE   = 4'd2;

    // code point limits
    localparam logic [CP_BITS-1:0] CP_CTRL_END = 21'h00001F;
    localparam logic [CP_BITS-1:0] CP_DEL      = 21'h00007F;
    localparam logic [CP_BITS-1:0] CP_BMP_END  = 21'h00FFFF;
    localparam logic [CP_BITS-1:0] CP_SYM_LO   = 21'h002600;
    localparam logic [CP_BITS-1:0] CP_SYM_HI   = 21'h0027BF;
    localparam logic [CP_BITS-1:0] CP_ARR_LO   = 21'h002B00;
    localparam logic [CP_BITS-1:0] CP_ARR_HI   = 21'h002BFF;
    localparam logic [CP_BITS-1:0] CP_JAMO_LO  = 21'h001100;
    localparam logic [CP_BITS-1:0] CP_JAMO_HI  = 21'h00115F;
    localparam logic [CP_BITS-1:0] CP_CJK_LO   = 21'h002E80;
    localparam logic [CP_BITS-1:0] CP_CJK_HI   = 21'h00A4CF;
    localparam logic [CP_BITS-1:0] CP_CJK_HOLE = 21'h00303F;
    localparam logic [CP_BITS-1:0] CP_HANG_LO  = 21'h00AC00;
    localparam logic [CP_BITS-1:0] CP_HANG_HI  = 21'h00D7A3;
    localparam logic [CP_BITS-1:0] CP_COMP_LO  = 21'h00F900;
    localparam logic [CP_BITS-1:0] CP_COMP_HI  = 21'h00FAFF;
    localparam logic [CP_BITS-1:0] CP_VERT_LO  = 21'h00FE30;
    localparam logic [CP_BITS-1:0] CP_VERT_HI  = 21'h00FE6F;
    localparam logic [CP_BITS-1:0] CP_FULL_LO  = 21'h00FF01;
    localparam logic [CP_BITS-1:0] CP_FULL_HI  = 21'h00FF60;
    localparam logic [CP_BITS-1:0] CP_FSYM_LO  = 21'h00FFE0;
    localparam logic [CP_BITS-1:0] CP_FSYM_HI  = 21'h00FFE6;
    localparam logic [CP_BITS-1:0] CP_EMO_LO   = 21'h01F300;
    localparam logic [CP_BITS-1:0] CP_EMO_HI   = 21'h01FAFF;
    localparam logic [CP_BITS-1:0] CP_MAHJ_LO  = 21'h01F000;
    localparam logic [CP_BITS-1:0] CP_MAHJ_HI  = 21'h01F02F;
    localparam logic [CP_BITS-1:0] CP_CARD_LO  = 21'h01F0A0;
    localparam logic [CP_BITS-1:0] CP_CARD_HI  = 21'h01F0FF;
    localparam logic [CP_BITS-1:0] CP_EXTE_LO  = 21'h02B700;
    localparam logic [CP_BITS-1:0] CP_EXTE_HI  = 21'h02EBEF;
    localparam logic [CP_BITS-1:0] CP_EXTG_LO  = 21'h030000;
    localparam logic [CP_BITS-1:0] CP_EXTG_HI  = 21'h03134F;

    // input item
    typedef struct packed {
        logic [BYTE_BITS-1:0] text_byte;
        logic                 end_of_text;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [WIDTH_BITS-1:0] cell_width;
        logic [COUNT_BITS-1:0] cell_byte_count;
        logic [CP_BITS-1:0]    code_point;
        logic [TOTAL_BITS-1:0] total_width;
        logic                  text_done;
    } t_out_item;

    // handshake between decode stage and result queue
    typedef struct packed {
        logic advance;
        logic room;
    } t_flow;

endpackage

`default_nettype wire

>>> rtl/utf8_cell_width_decoder_top.sv
// top level of the utf-8 cell width decoder
`default_nettype none

// Takes one text byte per item and returns one result item for each display cell
// (byte count, code point, width, saturating running width, end-of-text flag).
// Sustained rate is one byte per clock while the result queue has room. A byte is
// held in the input register, decoded combinationally against the sequence state,
// and the cell lands in a two-entry result queue before it is visible. Input ready
// drops only when both queue slots hold undelivered results. The tab width register
// is written through the cfg channel, which is always ready; the user must write it
// only while the block is idle, which the block does not check; its reset value is 4.
module utf8_cell_width_decoder_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire u8cw_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output u8cw_pkg::t_out_item                  o_out_item,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [u8cw_pkg::WIDTH_BITS-1:0] i_cfg_data
);

    logic                            r_in_valid, n_in_valid;
    u8cw_pkg::t_in_item              r_in_item;
    logic [u8cw_pkg::WIDTH_BITS-1:0] r_tab_width;
    u8cw_pkg::t_flow                 w_flow;
    logic                            w_advance;
    logic                            w_room;
    logic                            w_res_valid;
    u8cw_pkg::t_out_item             w_res_item;
    logic                            w_in_accept;

    // flow control between input register and result queue
    assign w_advance   = r_in_valid && w_room;
    assign w_flow      = '{advance: w_advance, room: w_room};
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // tab width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= u8cw_pkg::TAB_WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tab_width <= i_cfg_data;
        end
    end

    u8cw_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flow      (w_flow),
        .i_item      (r_in_item),
        .i_tab_width (r_tab_width),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item)
    );

    u8cw_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance && w_res_valid),
        .i_item  (w_res_item),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> rtl/u8cw_width_lut.sv
// display width classification of a decoded multi-byte code point
`default_nettype none

module u8cw_width_lut (
    input  wire logic [u8cw_pkg::CP_BITS-1:0]    i_cp,
    output logic      [u8cw_pkg::WIDTH_BITS-1:0] o_width
);

    logic w_wide_bmp;
    logic w_wide_hi;

    // wide ranges inside the basic plane
    always_comb begin
        w_wide_bmp = ((i_cp >= u8cw_pkg::CP_SYM_LO)  && (i_cp <= u8cw_pkg::CP_SYM_HI))  ||
                     ((i_cp >= u8cw_pkg::CP_ARR_LO)  && (i_cp <= u8cw_pkg::CP_ARR_HI))  ||
                     ((i_cp >= u8cw_pkg::CP_JAMO_LO) && (i_cp <= u8cw_pkg::CP_JAMO_HI)) ||
                     ((i_cp >= u8cw_pkg::CP_CJK_LO)  && (i_cp <= u8cw_pkg::CP_CJK_HI) &&
                      (i_cp != u8cw_pkg::CP_CJK_HOLE))                                 ||
                     ((i_cp >= u8cw_pkg::CP_HANG_LO) && (i_cp <= u8cw_pkg::CP_HANG_HI)) ||
                     ((i_cp >= u8cw_pkg::CP_COMP_LO) && (i_cp <= u8cw_pkg::CP_COMP_HI)) ||
                     ((i_cp >= u8cw_pkg::CP_VERT_LO) && (i_cp <= u8cw_pkg::CP_VERT_HI)) ||
                     ((i_cp >= u8cw_pkg::CP_FULL_LO) && (i_cp <= u8cw_pkg::CP_FULL_HI)) ||
                     ((i_cp >= u8cw_pkg::CP_FSYM_LO) && (i_cp <= u8cw_pkg::CP_FSYM_HI));
    end

    // wide ranges above the basic plane
    always_comb begin
        w_wide_hi = ((i_cp >= u8cw_pkg::CP_EMO_LO)  && (i_cp <= u8cw_pkg::CP_EMO_HI))  ||
                    ((i_cp >= u8cw_pkg::CP_MAHJ_LO) && (i_cp <= u8cw_pkg::CP_MAHJ_HI)) ||
                    ((i_cp >= u8cw_pkg::CP_CARD_LO) && (i_cp <= u8cw_pkg::CP_CARD_HI)) ||
                    ((i_cp >= u8cw_pkg::CP_EXTE_LO) && (i_cp <= u8cw_pkg::CP_EXTE_HI)) ||
                    ((i_cp >= u8cw_pkg::CP_EXTG_LO) && (i_cp <= u8cw_pkg::CP_EXTG_HI));
    end

    // control codes and delete are zero width
    always_comb begin
        if ((i_cp <= u8cw_pkg::CP_CTRL_END) || (i_cp == u8cw_pkg::CP_DEL)) begin
            o_width = u8cw_pkg::W_ZERO;
        end else if (i_cp <= u8cw_pkg::CP_BMP_END) begin
            o_width = w_wide_bmp ? u8cw_pkg::W_WIDE : u8cw_pkg::W_NARROW;
        end else begin
            o_width = w_wide_hi ? u8cw_pkg::W_WIDE : u8cw_pkg::W_NARROW;
        end
    end

endmodule

`default_nettype wire

>>> rtl/u8cw_decode.sv
// sequence state, cell formation and running width sum
`default_nettype none

module u8cw_decode (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire u8cw_pkg::t_flow                 i_flow,
    input  wire u8cw_pkg::t_in_item              i_item,
    input  wire logic [u8cw_pkg::WIDTH_BITS-1:0] i_tab_width,
    output logic                                 o_res_valid,
    output u8cw_pkg::t_out_item                  o_res_item
);

    localparam int SUM_EXT = u8cw_pkg::TOTAL_WIDTH_BITS + 1;

    logic [u8cw_pkg::REM_BITS-1:0]         r_rem, n_rem;
    logic [u8cw_pkg::COUNT_BITS-1:0]       r_seq, n_seq;
    logic [u8cw_pkg::CP_BITS-1:0]          r_pcp, n_pcp;
    logic [u8cw_pkg::TOTAL_WIDTH_BITS-1:0] r_sum, n_sum;

    logic [u8cw_pkg::BYTE_BITS-1:0]        w_byte;
    logic                                  w_last;
    logic [u8cw_pkg::CP_BITS-1:0]          w_shift_cp;
    logic [u8cw_pkg::WIDTH_BITS-1:0]       w_lut_width;
    logic [u8cw_pkg::WIDTH_BITS-1:0]       w_width;
    logic [u8cw_pkg::COUNT_BITS-1:0]       w_count;
    logic [u8cw_pkg::CP_BITS-1:0]          w_cp;
    logic                                  w_done;
    logic [SUM_EXT-1:0]                    w_sum_ext;
    logic [u8cw_pkg::TOTAL_WIDTH_BITS-1:0] w_sum_sat;

    assign w_byte     = i_item.text_byte;
    assign w_last     = i_item.end_of_text;
    assign w_shift_cp = {r_pcp[u8cw_pkg::CP_BITS-7:0], w_byte[5:0]};

    u8cw_width_lut u_lut (
        .i_cp    (w_shift_cp),
        .o_width (w_lut_width)
    );

    // next sequence state and the cell this byte completes
    always_comb begin
        n_rem       = r_rem;
        n_seq       = r_seq;
        n_pcp       = r_pcp;
        o_res_valid = 1'b0;
        w_width     = u8cw_pkg::W_NARROW;
        w_count     = u8cw_pkg::LEN_1;
        w_cp        = u8cw_pkg::CP_BITS'(w_byte);
        w_done      = w_last;
        if (r_rem != '0) begin
            n_pcp = w_shift_cp;
            n_rem = r_rem - 1'b1;
            w_cp  = w_shift_cp;
            if (n_rem == '0) begin
                o_res_valid = 1'b1;
                w_width     = w_lut_width;
                w_count     = r_seq;
            end else if (w_last) begin
                // text ends inside the sequence: emit what arrived
                o_res_valid = 1'b1;
                w_width     = (r_seq == u8cw_pkg::LEN_4) ? u8cw_pkg::W_WIDE
                                                         : u8cw_pkg::W_NARROW;
                w_count     = r_seq - u8cw_pkg::COUNT_BITS'(n_rem);
                w_done      = 1'b1;
                n_rem       = '0;
            end
        end else begin
            unique case (w_byte) inside
                8'b0???????: begin
                    o_res_valid = 1'b1;
                    if (w_byte < u8cw_pkg::CTRL_LIMIT) begin
                        w_width = (w_byte == u8cw_pkg::TAB_BYTE) ? i_tab_width
                                                                 : u8cw_pkg::W_ZERO;
                    end
                end
                8'b110?????: begin
                    n_seq = u8cw_pkg::LEN_2;
                    n_pcp = u8cw_pkg::CP_BITS'(w_byte & u8cw_pkg::LEAD2_MASK);
                end
                8'b1110????: begin
                    n_seq = u8cw_pkg::LEN_3;
                    n_pcp = u8cw_pkg::CP_BITS'(w_byte & u8cw_pkg::LEAD3_MASK);
                end
                8'b11110???: begin
                    n_seq = u8cw_pkg::LEN_4;
                    n_pcp = u8cw_pkg::CP_BITS'(w_byte & u8cw_pkg::LEAD4_MASK);
                end
                default: begin
                    // invalid lead forms a narrow one-byte cell
                    o_res_valid = 1'b1;
                end
            endcase
            if (n_seq != r_seq || n_pcp != r_pcp || !o_res_valid) begin
                if (!o_res_valid) begin
                    if (w_last) begin
                        // lead byte is the last of the text
                        o_res_valid = 1'b1;
                        w_width     = (n_seq == u8cw_pkg::LEN_4) ? u8cw_pkg::W_WIDE
                                                                 : u8cw_pkg::W_NARROW;
                        w_cp        = n_pcp;
                        w_done      = 1'b1;
                    end else begin
                        n_rem = u8cw_pkg::REM_BITS'(n_seq - 1'b1);
                    end
                end
            end
        end
    end

    // saturating running width
    always_comb begin
        w_sum_ext = {1'b0, r_sum} + SUM_EXT'(w_width);
        w_sum_sat = w_sum_ext[SUM_EXT-1] ? '1 : w_sum_ext[u8cw_pkg::TOTAL_WIDTH_BITS-1:0];
        n_sum     = r_sum;
        if (o_res_valid) begin
            n_sum = w_done ? '0 : w_sum_sat;
        end
    end

    // result fields
    always_comb begin
        o_res_item.cell_width      = w_width;
        o_res_item.cell_byte_count = w_count;
        o_res_item.code_point      = w_cp;
        o_res_item.total_width     = u8cw_pkg::TOTAL_BITS'(w_sum_sat);
        o_res_item.text_done       = w_done;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_seq <= '0;
            r_pcp <= '0;
            r_sum <= '0;
        end else if (i_flow.advance) begin
            r_rem <= n_rem;
            r_seq <= n_seq;
            r_pcp <= n_pcp;
            r_sum <= n_sum;
        end
    end

    // pending continuation count stays below the sequence length
    a_rem_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != '0) |-> (u8cw_pkg::COUNT_BITS'(r_rem) < r_seq))
        else $error("continuation count exceeds sequence length");

    // a cell never claims more bytes than a sequence holds
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_flow.advance && o_res_valid) |->
        ((o_res_item.cell_byte_count != 3'd0) &&
         (o_res_item.cell_byte_count <= u8cw_pkg::LEN_4)))
        else $error("cell byte count out of range");

    // running width restarts after the end of a text
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_flow.advance && o_res_valid && o_res_item.text_done) |=> (r_sum == '0))
        else $error("running width not cleared after text end");

    // the last byte of a text always closes a cell
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_flow.advance && i_item.end_of_text) |-> (o_res_valid && o_res_item.text_done))
        else $error("end of text without closing cell");

endmodule

`default_nettype wire

>>> rtl/u8cw_out_queue.sv
// two-entry result register with skid slot
`default_nettype none

module u8cw_out_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire u8cw_pkg::t_out_item i_item,
    output logic                     o_room,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output u8cw_pkg::t_out_item      o_item
);

    logic                r_main_valid, n_main_valid;
    logic                r_skid_valid, n_skid_valid;
    u8cw_pkg::t_out_item r_main, n_main;
    u8cw_pkg::t_out_item r_skid, n_skid;
    logic                w_pop;

    assign w_pop   = r_main_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

    // slot movement on push and pop
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_pop && r_skid_valid) begin
            n_main       = r_skid;
            n_skid_valid = i_push;
            n_skid       = i_item;
        end else if (w_pop) begin
            n_main_valid = i_push;
            n_main       = i_item;
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_item;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_item;
            end
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

>>> tb/tb_utf8_cell_width_decoder_top.sv
// self-checking testbench for the utf-8 cell width decoder top level
`default_nettype none

module tb_utf8_cell_width_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    // utf-8 prefix tags
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // end-of-text flag values
    localparam logic MORE = 1'b0;
    localparam logic LAST = 1'b1;

    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int WIDE_TABS    = 40;
    localparam int TEXT_BYTES   = 85;

    // directed texts: {byte, end of text}
    localparam logic [8:0] DIRECTED [27] = '{
        {8'h00, MORE}, {8'h09, MORE}, {8'h1F, MORE}, {8'h20, MORE}, {8'h7E, MORE},
        {8'h7F, MORE}, {8'h80, MORE}, {8'hBF, MORE}, {8'hF8, MORE}, {8'hFF, MORE},
        {8'hC2, MORE}, {8'hA9, MORE},
        {8'hC0, MORE}, {8'h80, MORE},
        {8'hE4, MORE}, {8'hB8, MORE}, {8'hAD, MORE},
        {8'hE3, MORE}, {8'h80, MORE}, {8'hBF, MORE},
        {8'hF0, MORE}, {8'h9F, MORE}, {8'h98, MORE}, {8'h80, LAST},
        {8'hF0, MORE}, {8'h9F, LAST},
        {8'hE4, LAST}
    };

    // code points on and next to the width range boundaries
    localparam logic [u8cw_pkg::CP_BITS-1:0] EDGE_CPS [34] = '{
        u8cw_pkg::CP_CTRL_END, u8cw_pkg::CP_DEL, 21'h0007FF, u8cw_pkg::CP_BMP_END,
        21'h1FFFFF,
        u8cw_pkg::CP_SYM_LO, u8cw_pkg::CP_SYM_HI, u8cw_pkg::CP_ARR_LO, u8cw_pkg::CP_ARR_HI,
        u8cw_pkg::CP_JAMO_LO, u8cw_pkg::CP_JAMO_HI,
        u8cw_pkg::CP_CJK_LO, u8cw_pkg::CP_CJK_HI, u8cw_pkg::CP_CJK_HOLE,
        u8cw_pkg::CP_HANG_LO, u8cw_pkg::CP_HANG_HI,
        u8cw_pkg::CP_COMP_LO, u8cw_pkg::CP_COMP_HI,
        u8cw_pkg::CP_VERT_LO, u8cw_pkg::CP_VERT_HI,
        u8cw_pkg::CP_FULL_LO, u8cw_pkg::CP_FULL_HI,
        u8cw_pkg::CP_FSYM_LO, u8cw_pkg::CP_FSYM_HI,
        u8cw_pkg::CP_EMO_LO, u8cw_pkg::CP_EMO_HI,
        u8cw_pkg::CP_MAHJ_LO, u8cw_pkg::CP_MAHJ_HI,
        u8cw_pkg::CP_CARD_LO, u8cw_pkg::CP_CARD_HI,
        u8cw_pkg::CP_EXTE_LO, u8cw_pkg::CP_EXTE_HI,
        u8cw_pkg::CP_EXTG_LO, u8cw_pkg::CP_EXTG_HI
    };

    // predicts cells from accepted bytes and checks delivered cells
    class cell_tracker;
        logic [u8cw_pkg::WIDTH_BITS-1:0]       tab_width;
        logic [u8cw_pkg::REM_BITS-1:0]         cont_left;
        logic [u8cw_pkg::COUNT_BITS-1:0]       seq_len;
        logic [u8cw_pkg::CP_BITS-1:0]          cp_acc;
        logic [u8cw_pkg::TOTAL_WIDTH_BITS-1:0] col_sum;
        u8cw_pkg::t_out_item                   expected_cells[$];
        int                                    errors;

        function new();
            tab_width = u8cw_pkg::TAB_WIDTH_RESET;
            cont_left = '0;
            seq_len   = '0;
            cp_acc    = '0;
            col_sum   = '0;
            errors    = 0;
        endfunction

        function bit in_span(logic [u8cw_pkg::CP_BITS-1:0] cp,
                             logic [u8cw_pkg::CP_BITS-1:0] lo,
                             logic [u8cw_pkg::CP_BITS-1:0] hi);
            return cp >= lo && cp <= hi;
        endfunction

        // display columns of a decoded code point
        function logic [u8cw_pkg::WIDTH_BITS-1:0] glyph_width(
            logic [u8cw_pkg::CP_BITS-1:0] cp);
            if (cp <= u8cw_pkg::CP_CTRL_END) return u8cw_pkg::W_ZERO;
            if (cp < u8cw_pkg::CP_DEL) return u8cw_pkg::W_NARROW;
            if (cp == u8cw_pkg::CP_DEL) return u8cw_pkg::W_ZERO;
            if (cp <= 21'h0007FF) return u8cw_pkg::W_NARROW;
            if (cp <= u8cw_pkg::CP_BMP_END) begin
                if (in_span(cp, u8cw_pkg::CP_SYM_LO, u8cw_pkg::CP_SYM_HI) ||
                    in_span(cp, u8cw_pkg::CP_ARR_LO, u8cw_pkg::CP_ARR_HI) ||
                    in_span(cp, u8cw_pkg::CP_JAMO_LO, u8cw_pkg::CP_JAMO_HI) ||
                    (in_span(cp, u8cw_pkg::CP_CJK_LO, u8cw_pkg::CP_CJK_HI) &&
                     cp != u8cw_pkg::CP_CJK_HOLE) ||
                    in_span(cp, u8cw_pkg::CP_HANG_LO, u8cw_pkg::CP_HANG_HI) ||
                    in_span(cp, u8cw_pkg::CP_COMP_LO, u8cw_pkg::CP_COMP_HI) ||
                    in_span(cp, u8cw_pkg::CP_VERT_LO, u8cw_pkg::CP_VERT_HI) ||
                    in_span(cp, u8cw_pkg::CP_FULL_LO, u8cw_pkg::CP_FULL_HI) ||
                    in_span(cp, u8cw_pkg::CP_FSYM_LO, u8cw_pkg::CP_FSYM_HI)) begin
                    return u8cw_pkg::W_WIDE;
                end
                return u8cw_pkg::W_NARROW;
            end
            if (in_span(cp, u8cw_pkg::CP_EMO_LO, u8cw_pkg::CP_EMO_HI) ||
                in_span(cp, u8cw_pkg::CP_MAHJ_LO, u8cw_pkg::CP_MAHJ_HI) ||
                in_span(cp, u8cw_pkg::CP_CARD_LO, u8cw_pkg::CP_CARD_HI) ||
                in_span(cp, u8cw_pkg::CP_EXTE_LO, u8cw_pkg::CP_EXTE_HI) ||
                in_span(cp, u8cw_pkg::CP_EXTG_LO, u8cw_pkg::CP_EXTG_HI)) begin
                return u8cw_pkg::W_WIDE;
            end
            return u8cw_pkg::W_NARROW;
        endfunction

        // queue a cell and advance the saturating column sum
        function void push_cell(logic [u8cw_pkg::WIDTH_BITS-1:0] w,
                                logic [u8cw_pkg::COUNT_BITS-1:0] count,
                                logic [u8cw_pkg::CP_BITS-1:0] cp, logic done);
            logic [u8cw_pkg::TOTAL_WIDTH_BITS:0] sum;
            u8cw_pkg::t_out_item                 entry;
            sum = {1'b0, col_sum} + w;
            if (sum[u8cw_pkg::TOTAL_WIDTH_BITS]) begin
                sum = {1'b0, {u8cw_pkg::TOTAL_WIDTH_BITS{1'b1}}};
            end
            col_sum = done ? '0 : sum[u8cw_pkg::TOTAL_WIDTH_BITS-1:0];
            entry.cell_width      = w;
            entry.cell_byte_count = count;
            entry.code_point      = cp;
            entry.total_width     = sum[u8cw_pkg::TOTAL_BITS-1:0];
            entry.text_done       = done;
            expected_cells.insert(expected_cells.size(), entry);
        endfunction

        // one accepted byte
        function void note_byte(logic [u8cw_pkg::BYTE_BITS-1:0] b, logic eot);
            logic [u8cw_pkg::WIDTH_BITS-1:0] w;
            // continuation byte inside a sequence
            if (cont_left != 0) begin
                cp_acc = {cp_acc[u8cw_pkg::CP_BITS-7:0], b[5:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == 0) begin
                    push_cell(glyph_width(cp_acc), seq_len, cp_acc, eot);
                end else if (eot) begin
                    push_cell(seq_len == u8cw_pkg::LEN_4 ? u8cw_pkg::W_WIDE
                                                         : u8cw_pkg::W_NARROW,
                              seq_len - cont_left, cp_acc, 1'b1);
                    cont_left = '0;
                end
                return;
            end
            // plain ascii
            if (!b[7]) begin
                if (b < u8cw_pkg::CTRL_LIMIT) begin
                    w = (b == u8cw_pkg::TAB_BYTE) ? tab_width : u8cw_pkg::W_ZERO;
                end else begin
                    w = u8cw_pkg::W_NARROW;
                end
                push_cell(w, u8cw_pkg::LEN_1, u8cw_pkg::CP_BITS'(b), eot);
                return;
            end
            // lead bytes, anything else is an invalid lead
            if (b[7:5] == LEAD2_TAG) begin
                seq_len = u8cw_pkg::LEN_2;
                cp_acc  = u8cw_pkg::CP_BITS'(b & u8cw_pkg::LEAD2_MASK);
            end else if (b[7:4] == LEAD3_TAG) begin
                seq_len = u8cw_pkg::LEN_3;
                cp_acc  = u8cw_pkg::CP_BITS'(b & u8cw_pkg::LEAD3_MASK);
            end else if (b[7:3] == LEAD4_TAG) begin
                seq_len = u8cw_pkg::LEN_4;
                cp_acc  = u8cw_pkg::CP_BITS'(b & u8cw_pkg::LEAD4_MASK);
            end else begin
                push_cell(u8cw_pkg::W_NARROW, u8cw_pkg::LEN_1, u8cw_pkg::CP_BITS'(b), eot);
                return;
            end
            // text cut off right after the lead
            if (eot) begin
                push_cell(seq_len == u8cw_pkg::LEN_4 ? u8cw_pkg::W_WIDE : u8cw_pkg::W_NARROW,
                          u8cw_pkg::LEN_1, cp_acc, 1'b1);
            end else begin
                cont_left = u8cw_pkg::REM_BITS'(seq_len - 1'b1);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // one delivered cell against the oldest prediction
        function void check_cell(u8cw_pkg::t_out_item got);
            u8cw_pkg::t_out_item want;
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected cell, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            compare_field("cell_width", want.cell_width, got.cell_width);
            compare_field("cell_byte_count", want.cell_byte_count, got.cell_byte_count);
            compare_field("code_point", want.code_point, got.code_point);
            compare_field("total_width", want.total_width, got.total_width);
            compare_field("text_done", want.text_done, got.text_done);
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    u8cw_pkg::t_in_item              i_in_item;
    logic                            o_out_valid;
    logic                            i_out_ready;
    u8cw_pkg::t_out_item             o_out_item;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [u8cw_pkg::WIDTH_BITS-1:0] i_cfg_data;

    cell_tracker      tracker = new();
    logic [7:0]       text_q[$];
    bit               tx_idle;
    bit               rx_idle;
    bit               hold_off_req;
    int               bytes_sent;
    int               quiet_cycles = 0;

    utf8_cell_width_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // encode a code point, keeping only the first bytes when cut off
    function automatic void put_cell(logic [u8cw_pkg::CP_BITS-1:0] cp, int len, int keep,
                                     bit messy);
        logic [7:0] seq [4];
        seq[1] = '0;
        seq[2] = '0;
        seq[3] = '0;
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {LEAD2_TAG, cp[10:6]};
                seq[1] = {CONT_TAG, cp[5:0]};
            end
            3: begin
                seq[0] = {LEAD3_TAG, cp[15:12]};
                seq[1] = {CONT_TAG, cp[11:6]};
                seq[2] = {CONT_TAG, cp[5:0]};
            end
            default: begin
                seq[0] = {LEAD4_TAG, cp[20:18]};
                seq[1] = {CONT_TAG, cp[17:12]};
                seq[2] = {CONT_TAG, cp[11:6]};
                seq[3] = {CONT_TAG, cp[5:0]};
            end
        endcase
        for (int k = 0; k < keep; k++) begin
            // continuation tags are not checked by the block
            if (k > 0 && messy) seq[k][7:6] = 2'($urandom);
            text_q.insert(text_q.size(), seq[k]);
        end
    endfunction

    // random code point and its encoded length
    function automatic void pick_code(output logic [u8cw_pkg::CP_BITS-1:0] cp,
                                      output int len);
        case ($urandom_range(0, 9))
            0: cp = u8cw_pkg::CP_BITS'($urandom_range(32'h20, 32'h7E));
            1: cp = ($urandom_range(0, 4) == 0) ? u8cw_pkg::CP_DEL
                                                : u8cw_pkg::CP_BITS'($urandom_range(0, 31));
            2: cp = u8cw_pkg::CP_BITS'(u8cw_pkg::TAB_BYTE);
            3: cp = u8cw_pkg::CP_BITS'($urandom_range(32'h80, 32'h7FF));
            4, 5: cp = EDGE_CPS[$urandom_range(0, 33)]
                       + u8cw_pkg::CP_BITS'($urandom_range(0, 2)) - 1'b1;
            6: cp = u8cw_pkg::CP_BITS'($urandom_range(32'h800, 32'hFFFF));
            7: cp = u8cw_pkg::CP_BITS'($urandom_range(u8cw_pkg::CP_EMO_LO,
                                                      u8cw_pkg::CP_EMO_HI));
            default: cp = u8cw_pkg::CP_BITS'($urandom_range(32'h10000, 32'h1FFFFF));
        endcase
        if (cp < 21'h80) len = 1;
        else if (cp < 21'h800) len = 2;
        else if (cp < 21'h10000) len = 3;
        else len = 4;
        // occasional overlong form
        if (len < 4 && $urandom_range(0, 9) == 0) len++;
    endfunction

    // one text: mostly well-formed cells, some noise, sometimes cut off
    function automatic void build_text();
        int                           n;
        int                           len;
        int                           keep;
        int                           kind;
        logic [u8cw_pkg::CP_BITS-1:0] cp;
        text_q.delete();
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                text_q.insert(text_q.size(),
                              ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                          : 8'($urandom_range(8'hF8, 8'hFF)));
            end else if (kind < 12) begin
                text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
            end else begin
                pick_code(cp, len);
                keep = len;
                if (k == n - 1 && len > 1 && $urandom_range(0, 4) == 0)
                    keep = $urandom_range(1, len - 1);
                put_cell(cp, len, keep, $urandom_range(0, 15) == 0);
            end
        end
    endfunction

    // offer one byte and wait for it to be taken; starts and ends at a falling edge
    task automatic send_byte(logic [u8cw_pkg::BYTE_BITS-1:0] b, logic eot);
        int gap;
        gap = tx_idle ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{text_byte: b, end_of_text: eot};
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_byte(b, eot);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // stop offering until every predicted cell is out and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.expected_cells.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // tab width write while idle
    task automatic write_tab(logic [u8cw_pkg::WIDTH_BITS-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.tab_width = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random texts until about count more bytes went in
    task automatic run_texts(int count, bit gaps);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            tx_idle = gaps && ($urandom_range(0, 3) != 0);
            build_text();
            foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
            if ($urandom_range(0, 24) == 0) wait_idle();
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (rx_idle && stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_cell(o_out_item);
    end

    // cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_off_req = 1'b0;
        bytes_sent   = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed cases at the reset tab width
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][8:1], DIRECTED[i][0]);

        // zero-width tabs
        write_tab(u8cw_pkg::W_ZERO);
        run_texts(TEXT_BYTES, 1'b1);

        // widest tabs in one long text
        write_tab({u8cw_pkg::WIDTH_BITS{1'b1}});
        tx_idle = 1'b0;
        for (int k = 0; k < WIDE_TABS; k++) send_byte(u8cw_pkg::TAB_BYTE, k == WIDE_TABS - 1);

        // long receiver hold-off while bytes keep coming
        hold_off_req = 1'b1;
        run_texts(TEXT_BYTES, 1'b0);

        // no idling on either side
        write_tab(u8cw_pkg::WIDTH_BITS'($urandom_range(1, 14)));
        rx_idle = 1'b0;
        run_texts(TEXT_BYTES, 1'b0);

        write_tab(u8cw_pkg::W_NARROW);
        rx_idle = 1'b1;
        run_texts(TEXT_BYTES, 1'b1);

        wait_idle();
        if (tracker.errors == 0 && tracker.expected_cells.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
